// ===== src/playfair_encipher_core_defines.svh =====
// assertion macros shared by the playfair encipher checker
`ifndef PLAYFAIR_ENCIPHER_CORE_DEFINES_SVH
`define PLAYFAIR_ENCIPHER_CORE_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define PFE_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define PFE_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== src/pfe_pkg.sv =====
// shared constants, types and letter helpers for the playfair encipher core
`timescale 1ns / 1ps

package pfe_pkg;

   localparam int SQUARE_SIDE = 5;
   localparam int ALPHABET    = 26;
   localparam int LETTER_W    = 5;
   localparam int POS_W       = 3;
   localparam int POSITION_W  = 2 * POS_W;
   localparam int LETTER_AW   = $clog2(ALPHABET);

   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;
   localparam logic [LETTER_W-1:0] CODE_X = 5'd23;

   // one placement into the key square
   typedef struct packed {
      logic                en;
      logic [LETTER_W-1:0] letter;
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
   } place_type;

   // out-of-range codes become x, j folds into i
   function automatic logic [LETTER_W-1:0] normalize(input logic [LETTER_W-1:0] code);
      logic [LETTER_W-1:0] c;
      c = code;
      if (c >= LETTER_W'(ALPHABET)) begin
         c = CODE_X;
      end
      if (c == CODE_J) begin
         c = CODE_I;
      end
      return c;
   endfunction

endpackage

// ===== src/pfe_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pfe_key_fill.sv =====
// key square fill tracking: used flags, fill count and next free cell
`timescale 1ns / 1ps

module pfe_key_fill #(
   parameter int SQUARE_SIDE = pfe_pkg::SQUARE_SIDE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  place_en,
   input  logic [pfe_pkg::LETTER_W-1:0]          place_letter,
   output pfe_pkg::place_type                    place,
   output logic [$clog2(SQUARE_SIDE*SQUARE_SIDE)-1:0]   place_cell,
   output logic [$clog2(SQUARE_SIDE*SQUARE_SIDE+1)-1:0] fill_count,
   output logic [pfe_pkg::ALPHABET-1:0]          used
);

   localparam int CELLS   = SQUARE_SIDE * SQUARE_SIDE;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int FILL_W  = $clog2(CELLS + 1);

   logic [pfe_pkg::ALPHABET-1:0] used_ff;
   logic [FILL_W-1:0]            fill_ff;
   logic [pfe_pkg::POS_W-1:0]    row_ff;
   logic [pfe_pkg::POS_W-1:0]    col_ff;
   logic                         full;

   assign full = (fill_ff == FILL_W'(CELLS));

   always_comb begin
      place.en     = place_en && !full
                     && !used_ff[place_letter[pfe_pkg::LETTER_AW-1:0]];
      place.letter = place_letter;
      place.row    = row_ff;
      place.col    = col_ff;
   end

   assign place_cell = fill_ff[CELL_AW-1:0];
   assign fill_count = fill_ff;
   assign used       = used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         fill_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (place.en) begin
         used_ff[place_letter[pfe_pkg::LETTER_AW-1:0]] <= 1'b1;
         fill_ff <= fill_ff + FILL_W'(1);
         if (col_ff == pfe_pkg::POS_W'(SQUARE_SIDE - 1)) begin
            col_ff <= '0;
            row_ff <= row_ff + pfe_pkg::POS_W'(1);
         end else begin
            col_ff <= col_ff + pfe_pkg::POS_W'(1);
         end
      end
   end

endmodule

// ===== src/pfe_out_buf.sv =====
// two-entry result buffer that hands out one enciphered pair
`timescale 1ns / 1ps

module pfe_out_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [pfe_pkg::LETTER_W-1:0] first_letter,
   input  logic [pfe_pkg::LETTER_W-1:0] second_letter,
   input  logic                         last_pair,
   output logic                         empty,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pfe_pkg::LETTER_W-1:0] rsp_cipher_letter,
   output logic                         rsp_last_out
);

   logic [1:0]                   count_ff;
   logic [pfe_pkg::LETTER_W-1:0] first_ff;
   logic [pfe_pkg::LETTER_W-1:0] second_ff;
   logic                         last_ff;

   assign empty             = (count_ff == 2'd0);
   assign rsp_valid         = !empty;
   assign rsp_cipher_letter = (count_ff == 2'd2) ? first_ff : second_ff;
   assign rsp_last_out      = (count_ff == 2'd1) && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (load && empty) begin
         count_ff <= 2'd2;
      end else if (rsp_valid && rsp_ready) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load && empty) begin
         first_ff  <= first_letter;
         second_ff <= second_letter;
         last_ff   <= last_pair;
      end
   end

endmodule

// ===== src/playfair_encipher_core.sv =====
// playfair encipher core: key square build, letter pairing and pair lookup
// a message pair's first cipher letter appears once its closing letter has passed POSA, POSB, CALC, CELLA, CELLB, DONE
// key letters and pair openers leave the core ready for the next item; a closing letter holds
//   req_ready low for two position-ram and two square-ram reads in sequence, longer while a pair waits
// the last key letter starts a walk over the alphabet to fill the square
// synchronous active-high reset empties the square, the pairing state and the result buffer
`timescale 1ns / 1ps

module playfair_encipher_core #(
   parameter int SQUARE_SIDE = pfe_pkg::SQUARE_SIDE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_func,
   input  logic [pfe_pkg::LETTER_W-1:0] req_letter,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pfe_pkg::LETTER_W-1:0] rsp_cipher_letter,
   output logic                         rsp_last_out
);

   localparam int CELLS   = SQUARE_SIDE * SQUARE_SIDE;
   localparam int CELL_AW = $clog2(CELLS);
   localparam int FILL_W  = $clog2(CELLS + 1);
   localparam int LW      = pfe_pkg::LETTER_W;
   localparam int PW      = pfe_pkg::POS_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // take items
   localparam logic [2:0] ST_FILL  = 3'd1;  // walk the alphabet after the last key letter
   localparam logic [2:0] ST_POSA  = 3'd2;  // read position of first pair letter
   localparam logic [2:0] ST_POSB  = 3'd3;  // read position of second pair letter
   localparam logic [2:0] ST_CALC  = 3'd4;  // row/column rules, cell addresses
   localparam logic [2:0] ST_CELLA = 3'd5;  // read first cipher cell
   localparam logic [2:0] ST_CELLB = 3'd6;  // read second cipher cell
   localparam logic [2:0] ST_DONE  = 3'd7;  // hand the pair to the result buffer

   logic [2:0]   state_ff, state_in;
   logic [LW-1:0] walk_ff;          // alphabet walk letter
   logic [LW-1:0] held_ff;          // first letter of an open pair
   logic          held_valid_ff;
   logic [LW-1:0] prev_ff;          // previous message letter after replacement
   logic          prev_valid_ff;
   logic [LW-1:0] pair_a_ff, pair_b_ff;
   logic          pair_last_ff;
   logic [pfe_pkg::POSITION_W-1:0] pos_a_ff;
   logic [CELL_AW-1:0] addr1_ff, addr2_ff, addr1_in, addr2_in;
   logic [LW-1:0] o1_ff;

   logic          accept;
   logic [LW-1:0] letter_n;
   logic [LW-1:0] msg_letter;

   // key fill and ram ports
   logic                      place_en;
   logic [LW-1:0]             place_letter;
   pfe_pkg::place_type        place;
   logic [CELL_AW-1:0]        place_cell;
   logic [FILL_W-1:0]         fill_count;
   logic [pfe_pkg::ALPHABET-1:0] used;

   logic [pfe_pkg::POSITION_W-1:0] pos_rdata, pos_b;
   logic [LW-1:0]                  sq_rdata, o2;
   logic                           buf_empty;
   logic                           buf_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // j folds into i, repeat of the previous message letter becomes x
   assign letter_n   = pfe_pkg::normalize(req_letter);
   assign msg_letter = (prev_valid_ff && (letter_n == prev_ff)) ? pfe_pkg::CODE_X : letter_n;

   // placement: key letter on accept, or one alphabet letter per walk cycle (j skipped)
   assign place_en     = (accept && !req_func)
                         || ((state_ff == ST_FILL) && (walk_ff != pfe_pkg::CODE_J));
   assign place_letter = (state_ff == ST_FILL) ? walk_ff : letter_n;

   pfe_key_fill #(
      .SQUARE_SIDE(SQUARE_SIDE)
   ) u_key_fill (
      .clock       (clock),
      .reset       (reset),
      .place_en    (place_en),
      .place_letter(place_letter),
      .place       (place),
      .place_cell  (place_cell),
      .fill_count  (fill_count),
      .used        (used)
   );

   // letter -> {row, col}; an unplaced letter reads as row 0 column 0
   pfe_ram #(
      .WIDTH(pfe_pkg::POSITION_W),
      .DEPTH(pfe_pkg::ALPHABET)
   ) u_pos_ram (
      .clock  (clock),
      .wr_en  (place.en),
      .wr_addr(place.letter[pfe_pkg::LETTER_AW-1:0]),
      .wr_data({place.row, place.col}),
      .rd_en  ((state_ff == ST_POSA) || (state_ff == ST_POSB)),
      .rd_addr((state_ff == ST_POSA) ? pair_a_ff[pfe_pkg::LETTER_AW-1:0]
                                     : pair_b_ff[pfe_pkg::LETTER_AW-1:0]),
      .rd_data(pos_rdata)
   );

   // cell -> letter, row-major; an unfilled cell reads as a
   pfe_ram #(
      .WIDTH(LW),
      .DEPTH(CELLS)
   ) u_square_ram (
      .clock  (clock),
      .wr_en  (place.en),
      .wr_addr(place_cell),
      .wr_data(place.letter),
      .rd_en  ((state_ff == ST_CELLA) || (state_ff == ST_CELLB)),
      .rd_addr((state_ff == ST_CELLA) ? addr1_ff : addr2_ff),
      .rd_data(sq_rdata)
   );

   // second position arrives in the calc cycle
   assign pos_b = used[pair_b_ff[pfe_pkg::LETTER_AW-1:0]] ? pos_rdata : '0;

   // playfair rules on the two positions
   always_comb begin
      logic [PW-1:0] r1, c1, r2, c2;
      logic [PW-1:0] r1n, c1n, r2n, c2n;
      logic [PW-1:0] row1, col1, row2, col2;
      r1  = pos_a_ff[2*PW-1:PW];
      c1  = pos_a_ff[PW-1:0];
      r2  = pos_b[2*PW-1:PW];
      c2  = pos_b[PW-1:0];
      r1n = (r1 == PW'(SQUARE_SIDE - 1)) ? '0 : r1 + PW'(1);
      c1n = (c1 == PW'(SQUARE_SIDE - 1)) ? '0 : c1 + PW'(1);
      r2n = (r2 == PW'(SQUARE_SIDE - 1)) ? '0 : r2 + PW'(1);
      c2n = (c2 == PW'(SQUARE_SIDE - 1)) ? '0 : c2 + PW'(1);
      if (r1 == r2) begin
         // same row: shift right
         row1 = r1;  col1 = c1n;
         row2 = r2;  col2 = c2n;
      end else if (c1 == c2) begin
         // same column: shift down
         row1 = r1n; col1 = c1;
         row2 = r2n; col2 = c2;
      end else begin
         // rectangle: swap corners
         row1 = r1;  col1 = c2;
         row2 = r2;  col2 = c1;
      end
      addr1_in = CELL_AW'(int'(row1) * SQUARE_SIDE + int'(col1));
      addr2_in = CELL_AW'(int'(row2) * SQUARE_SIDE + int'(col2));
   end

   assign o2       = (FILL_W'(addr2_ff) < fill_count) ? sq_rdata : '0;
   assign buf_load = (state_ff == ST_DONE) && buf_empty;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_func) begin
                  if (req_last) begin
                     state_in = ST_FILL;
                  end
               end else if (held_valid_ff || req_last) begin
                  state_in = ST_POSA;
               end
            end
         end
         ST_FILL: begin
            if (walk_ff == LW'(pfe_pkg::ALPHABET - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_POSA:  state_in = ST_POSB;
         ST_POSB:  state_in = ST_CALC;
         ST_CALC:  state_in = ST_CELLA;
         ST_CELLA: state_in = ST_CELLB;
         ST_CELLB: state_in = ST_DONE;
         ST_DONE: begin
            // wait for the previous pair to drain
            if (buf_empty) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_ff       <= '0;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
         prev_valid_ff <= 1'b0;
         prev_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FILL) begin
            walk_ff <= walk_ff + LW'(1);
         end
         if (accept && !req_func && req_last) begin
            walk_ff <= '0;
         end
         if (accept && req_func) begin
            if (held_valid_ff) begin
               held_valid_ff <= 1'b0;
            end else if (!req_last) begin
               held_ff       <= msg_letter;
               held_valid_ff <= 1'b1;
            end
            if (req_last) begin
               // message ends: next one starts afresh
               held_valid_ff <= 1'b0;
               held_ff       <= '0;
               prev_valid_ff <= 1'b0;
               prev_ff       <= '0;
            end else begin
               prev_valid_ff <= 1'b1;
               prev_ff       <= msg_letter;
            end
         end
      end
   end

   // pair datapath registers
   always_ff @(posedge clock) begin
      if (accept && req_func) begin
         pair_a_ff    <= held_valid_ff ? held_ff : msg_letter;
         pair_b_ff    <= held_valid_ff ? msg_letter : pfe_pkg::CODE_X;
         pair_last_ff <= req_last;
      end
      if (state_ff == ST_POSB) begin
         pos_a_ff <= used[pair_a_ff[pfe_pkg::LETTER_AW-1:0]] ? pos_rdata : '0;
      end
      if (state_ff == ST_CALC) begin
         addr1_ff <= addr1_in;
         addr2_ff <= addr2_in;
      end
      if (state_ff == ST_CELLB) begin
         o1_ff <= (FILL_W'(addr1_ff) < fill_count) ? sq_rdata : '0;
      end
   end

   pfe_out_buf u_out_buf (
      .clock            (clock),
      .reset            (reset),
      .load             (buf_load),
      .first_letter     (o1_ff),
      .second_letter    (o2),
      .last_pair        (pair_last_ff),
      .empty            (buf_empty),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cipher_letter(rsp_cipher_letter),
      .rsp_last_out     (rsp_last_out)
   );

endmodule

// ===== src/pfe_checker.sv =====
// port-level checker for the playfair encipher core, bound to the top level
`timescale 1ns / 1ps
`include "playfair_encipher_core_defines.svh"

module pfe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_func,
   input logic                         req_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pfe_pkg::LETTER_W-1:0] rsp_cipher_letter,
   input logic                         rsp_last_out
);

   logic in_acc;
   logic key_end;
   logic letter_ok;

   assign in_acc    = req_valid && req_ready;
   assign key_end   = in_acc && !req_func && req_last;
   assign letter_ok = (rsp_cipher_letter < pfe_pkg::LETTER_W'(pfe_pkg::ALPHABET))
                      && (rsp_cipher_letter != pfe_pkg::CODE_J);

   // stalled result holds
   `PFE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_cipher_letter) && $stable(rsp_last_out),
      "stalled result changed")

   // square only holds letters, never j
   `PFE_ASSERT_IMP(a_rsp_letter, clock, reset, rsp_valid, letter_ok,
      "cipher letter out of range or j")

   // nothing comes out right after reset
   `PFE_ASSERT_NXT(a_rst_quiet, clock, 1'b0, reset, !rsp_valid,
      "result valid after reset")

   // last key letter starts the alphabet walk
   `PFE_ASSERT_NXT(a_fill_busy, clock, reset, key_end, !req_ready,
      "ready during square fill")

endmodule

bind playfair_encipher_core pfe_checker u_pfe_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_func         (req_func),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_cipher_letter(rsp_cipher_letter),
   .rsp_last_out     (rsp_last_out)
);
